// ===== sv/taylor_sine_approximation_macros.svh =====
// Assertion helpers for the assertion checker of the sine block.
`ifndef TAYLOR_SINE_APPROXIMATION_MACROS_SVH
`define TAYLOR_SINE_APPROXIMATION_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define TSA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define TSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== sv/tsa_pkg.sv =====
`timescale 1ns / 1ps
package tsa_pkg;

    // Port field widths
    localparam int ANGLE_W = 32;
    localparam int SINE_W  = 32;
    localparam int CNT_W   = 7;
    localparam int EPS_W   = 31;
    localparam int OUT_TDATA_W = 40;

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

    // Parameter defaults
    localparam int MAX_TERMS_DEF       = 32;
    localparam int ANGLE_FRAC_BITS_DEF = 24;

    // Range reduction: magnitude in Q.48 modulo 2*pi in Q.48
    localparam int RED_FRAC = 48;
    localparam int RED_W    = 51;
    localparam logic [RED_W-1:0] TWO_PI_RED = RED_W'(52'h6487ED5110B46);

    // Rounding shifts from the reduced angle to x (Q.40) and first term (Q.30)
    localparam int X_SHIFT = RED_FRAC - 40;
    localparam int T_SHIFT = RED_FRAC - 30;

    // Datapath widths
    localparam int X2_W   = 36;
    localparam int TERM_W = 38;
    localparam int SUM_W  = 44;

    // Shared multiplier
    localparam int MUL_A_W     = 44;
    localparam int MUL_B_W     = 48;
    localparam int MUL_CHUNK_W = 16;
    localparam int MUL_OUT_W   = 44;
    localparam int SQ_SHIFT    = 50;
    localparam int TERM_SHIFT  = 30;

    // Term divider
    localparam int DIV_W          = 48;
    localparam int DIV_RADIX_BITS = 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_SQUARE,
        S_ACCUM,
        S_MUL,
        S_DIV_GO,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic {
        MUL_SQUARE,
        MUL_TERM
    } t_mul_mode;

    typedef struct packed {
        logic      start;
        t_mul_mode mode;
    } t_mul_req;

endpackage

// ===== sv/tsa_reduce.sv =====
`timescale 1ns / 1ps
// Serial remainder of (magnitude << shift) modulo 2*pi, one bit per cycle.
module tsa_reduce #(
    parameter int ANGLE_FRAC_BITS = tsa_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tsa_pkg::ANGLE_W-1:0] i_mag,
    output logic                        o_done,
    output logic [tsa_pkg::RED_W-1:0]   o_rem
);

    localparam int SHIFT      = tsa_pkg::RED_FRAC - ANGLE_FRAC_BITS;
    localparam int NUM_W      = tsa_pkg::ANGLE_W + SHIFT;
    localparam int PRE_W      = tsa_pkg::RED_W - 1;
    localparam int STEPS      = NUM_W - PRE_W;
    localparam int STEP_CNT_W = $clog2(STEPS + 1);

    logic [NUM_W-1:0]            num;
    logic [tsa_pkg::RED_W:0]     rem2;
    logic [tsa_pkg::RED_W:0]     rem_sub;
    logic                        fits;

    logic                        r_busy;
    logic                        r_done;
    logic [STEP_CNT_W-1:0]       r_cnt;
    logic [tsa_pkg::RED_W-1:0]   r_rem;
    logic [STEPS-1:0]            r_low;

    assign num     = {i_mag, {SHIFT{1'b0}}};
    assign rem2    = {r_rem, r_low[STEPS-1]};
    assign fits    = rem2 >= {1'b0, tsa_pkg::TWO_PI_RED};
    assign rem_sub = rem2 - {1'b0, tsa_pkg::TWO_PI_RED};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The top bits are always below 2*pi, so they preload the remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, num[NUM_W-1 -: PRE_W]};
            r_low <= num[STEPS-1:0];
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[tsa_pkg::RED_W-1:0] : rem2[tsa_pkg::RED_W-1:0];
            r_low <= r_low << 1;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== sv/tsa_mul.sv =====
`timescale 1ns / 1ps
// Shared multiplier: one 16-bit slice of B per cycle, then a rounded shift.
module tsa_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tsa_pkg::t_mul_req             i_req,
    input  logic [tsa_pkg::MUL_A_W-1:0]   i_a,
    input  logic [tsa_pkg::MUL_B_W-1:0]   i_b,
    output logic                          o_done,
    output logic [tsa_pkg::MUL_OUT_W-1:0] o_result
);

    localparam int CHUNKS      = tsa_pkg::MUL_B_W / tsa_pkg::MUL_CHUNK_W;
    localparam int CHUNK_CNT_W = $clog2(CHUNKS);
    localparam int PP_W        = tsa_pkg::MUL_A_W + tsa_pkg::MUL_CHUNK_W;
    localparam int WIDE_W      = tsa_pkg::SQ_SHIFT + tsa_pkg::MUL_OUT_W;

    logic [PP_W-1:0]                 pp_sum;
    logic [WIDE_W-1:0]               wide;

    logic                            r_busy;
    logic                            r_done;
    logic [CHUNK_CNT_W-1:0]          r_cnt;
    tsa_pkg::t_mul_mode              r_mode;
    logic [tsa_pkg::MUL_A_W-1:0]     r_a;
    logic [tsa_pkg::MUL_B_W-1:0]     r_b;
    logic [tsa_pkg::MUL_A_W-1:0]     r_hi;
    logic [tsa_pkg::MUL_B_W-1:0]     r_lo;

    assign pp_sum = PP_W'(r_hi) + r_a * r_b[tsa_pkg::MUL_CHUNK_W-1:0];
    assign wide   = WIDE_W'({r_hi, r_lo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CHUNK_CNT_W'(CHUNKS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_hi   <= '0;
            r_mode <= i_req.mode;
        end else if (r_busy) begin
            r_hi <= pp_sum[PP_W-1:tsa_pkg::MUL_CHUNK_W];
            r_lo <= {pp_sum[tsa_pkg::MUL_CHUNK_W-1:0],
                     r_lo[tsa_pkg::MUL_B_W-1:tsa_pkg::MUL_CHUNK_W]};
            r_b  <= r_b >> tsa_pkg::MUL_CHUNK_W;
        end
    end

    // Round half up: add the bit just below the cut
    always_comb begin
        unique case (r_mode)
            tsa_pkg::MUL_SQUARE: begin
                o_result = wide[tsa_pkg::SQ_SHIFT +: tsa_pkg::MUL_OUT_W]
                         + tsa_pkg::MUL_OUT_W'(wide[tsa_pkg::SQ_SHIFT-1]);
            end
            tsa_pkg::MUL_TERM: begin
                o_result = wide[tsa_pkg::TERM_SHIFT +: tsa_pkg::MUL_OUT_W]
                         + tsa_pkg::MUL_OUT_W'(wide[tsa_pkg::TERM_SHIFT-1]);
            end
        endcase
    end

    assign o_done = r_done;

endmodule

// ===== sv/tsa_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, four quotient bits per cycle.
module tsa_div #(
    parameter int DIVISOR_W = 13
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tsa_pkg::DIV_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]      i_divisor,
    output logic                      o_done,
    output logic [tsa_pkg::DIV_W-1:0] o_quot
);

    localparam int CYCLES    = tsa_pkg::DIV_W / tsa_pkg::DIV_RADIX_BITS;
    localparam int CYC_CNT_W = $clog2(CYCLES);

    logic [tsa_pkg::DIV_W-1:0] q_nx;
    logic [DIVISOR_W-1:0]      rem_nx;

    logic                      r_busy;
    logic                      r_done;
    logic [CYC_CNT_W-1:0]      r_cnt;
    logic [tsa_pkg::DIV_W-1:0] r_q;
    logic [DIVISOR_W-1:0]      r_rem;
    logic [DIVISOR_W-1:0]      r_d;

    always_comb begin
        logic [DIVISOR_W:0] trial;
        rem_nx = r_rem;
        q_nx   = r_q;
        trial  = '0;
        for (int i = 0; i < tsa_pkg::DIV_RADIX_BITS; i++) begin
            trial = {rem_nx, q_nx[tsa_pkg::DIV_W-1]};
            q_nx  = {q_nx[tsa_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_d}) begin
                trial   = trial - {1'b0, r_d};
                q_nx[0] = 1'b1;
            end
            rem_nx = trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CYC_CNT_W'(CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient bits shift in where dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= q_nx;
            r_rem <= rem_nx;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== sv/taylor_sine_approximation.sv =====
`timescale 1ns / 1ps
// Channel     | Dir | Transfer when         | Payload
// ------------+-----+-----------------------+----------------------------------------
// s_axis      | in  | tvalid & tready       | tdata[31:0] angle (Q8.24 default)
// m_axis      | out | tvalid & tready       | tdata[31:0] sine_value, [38:32] terms_used,
//             |     |                       | [39] hit_limit
// cfg         | in  | i_cfg_wr_en high      | i_cfg_wr_data[30:0] epsilon_threshold
//
// One angle in flight: no new angle is taken until the last result is loaded,
// and the result shows up as the input side becomes ready again.
// Each extra term costs one pass of the multiplier and one of the divider, plus
// the sequencing around them.
// Reset is synchronous and active low; it puts epsilon back to 1 and empties the output.
// A result waits in the output register while the next angle is taken; a stalled
// result only holds the finished item before it is moved out.
module taylor_sine_approximation #(
    parameter int MAX_TERMS       = tsa_pkg::MAX_TERMS_DEF,
    parameter int ANGLE_FRAC_BITS = tsa_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [tsa_pkg::EPS_W-1:0]       i_cfg_wr_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [tsa_pkg::ANGLE_W-1:0]     i_s_axis_tdata,   // [31:0] angle
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [tsa_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata    // [31:0] sine_value,
                                                              // [38:32] terms_used,
                                                              // [39] hit_limit
);

    // k = (2n+2)(2n+3) walks up by 14, 22, 30, ...
    localparam int K_W        = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS + 1) + 1);
    localparam int K_FIRST    = 6;
    localparam int K_STEP_1ST = 14;
    localparam int K_STEP_INC = 8;

    localparam logic signed [tsa_pkg::SUM_W-1:0] SINE_MAX =
        {{(tsa_pkg::SUM_W - tsa_pkg::SINE_W + 1){1'b0}}, {(tsa_pkg::SINE_W - 1){1'b1}}};
    localparam logic signed [tsa_pkg::SUM_W-1:0] SINE_MIN =
        {{(tsa_pkg::SUM_W - tsa_pkg::SINE_W + 1){1'b1}}, {(tsa_pkg::SINE_W - 1){1'b0}}};

    tsa_pkg::t_state                    r_state;
    tsa_pkg::t_state                    n_state;

    logic [tsa_pkg::EPS_W-1:0]          r_eps;
    logic                               r_neg;
    logic [tsa_pkg::TERM_W-1:0]         r_term;
    logic [tsa_pkg::X2_W-1:0]           r_x2;
    logic [tsa_pkg::MUL_OUT_W-1:0]      r_prod;
    logic [K_W-1:0]                     r_k;
    logic [K_W-1:0]                     r_kinc;
    logic signed [tsa_pkg::SUM_W-1:0]   r_sum;
    logic [tsa_pkg::CNT_W-1:0]          r_count;
    logic                               r_hit;
    logic                               r_out_valid;
    logic [tsa_pkg::OUT_TDATA_W-1:0]    r_out_data;

    logic                               s_accept;
    logic [tsa_pkg::ANGLE_W-1:0]        mag;
    logic                               red_start;
    logic                               red_done;
    logic [tsa_pkg::RED_W-1:0]          red_rem;
    tsa_pkg::t_mul_req                  mul_req;
    logic [tsa_pkg::MUL_A_W-1:0]        mul_a;
    logic [tsa_pkg::MUL_B_W-1:0]        mul_b;
    logic                               mul_done;
    logic [tsa_pkg::MUL_OUT_W-1:0]      mul_result;
    logic                               div_start;
    logic                               div_done;
    logic [tsa_pkg::DIV_W-1:0]          div_dividend;
    logic [tsa_pkg::DIV_W-1:0]          div_quot;
    logic                               out_load;

    logic [tsa_pkg::MUL_A_W-1:0]        x40;
    logic [tsa_pkg::TERM_W-1:0]         term_first;
    logic                               term_neg;
    logic signed [tsa_pkg::SUM_W-1:0]   term_ext;
    logic signed [tsa_pkg::SUM_W-1:0]   sum_next;
    logic [tsa_pkg::CNT_W-1:0]          count_next;
    logic                               term_small;
    logic                               count_full;
    logic [tsa_pkg::SINE_W-1:0]         sine_sat;

    assign o_s_axis_tready = (r_state == tsa_pkg::S_IDLE) && i_rst_n;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Two's complement magnitude; the most negative angle gives 2^31 exactly
    assign mag = i_s_axis_tdata[tsa_pkg::ANGLE_W-1] ? (~i_s_axis_tdata + 1'b1)
                                                    : i_s_axis_tdata;

    // Round half up from the Q.48 reduced angle
    assign x40 = tsa_pkg::MUL_A_W'(red_rem[tsa_pkg::RED_W-1:tsa_pkg::X_SHIFT])
               + tsa_pkg::MUL_A_W'(red_rem[tsa_pkg::X_SHIFT-1]);
    assign term_first = tsa_pkg::TERM_W'(red_rem[tsa_pkg::RED_W-1:tsa_pkg::T_SHIFT])
                      + tsa_pkg::TERM_W'(red_rem[tsa_pkg::T_SHIFT-1]);

    // Odd-numbered terms flip the sign of the angle
    assign term_neg   = r_neg ^ r_count[0];
    assign term_ext   = $signed({{(tsa_pkg::SUM_W - tsa_pkg::TERM_W){1'b0}}, r_term});
    assign sum_next   = term_neg ? (r_sum - term_ext) : (r_sum + term_ext);
    assign count_next = r_count + 1'b1;
    assign term_small = {{(tsa_pkg::TERM_W - tsa_pkg::EPS_W){1'b0}}, r_eps} >= r_term;
    assign count_full = count_next >= tsa_pkg::CNT_W'(MAX_TERMS);

    // Squaring takes x twice; term steps take the running term and x^2
    assign mul_a = (r_state == tsa_pkg::S_REDUCE) ? x40
                                                   : tsa_pkg::MUL_A_W'(r_term);
    assign mul_b = (r_state == tsa_pkg::S_REDUCE) ? tsa_pkg::MUL_B_W'(x40)
                                                   : tsa_pkg::MUL_B_W'(r_x2);

    // Round the quotient half up by adding k/2 to the dividend
    assign div_dividend = tsa_pkg::DIV_W'(r_prod) + tsa_pkg::DIV_W'(r_k >> 1);

    always_comb begin
        if (r_sum > SINE_MAX) begin
            sine_sat = SINE_MAX[tsa_pkg::SINE_W-1:0];
        end else if (r_sum < SINE_MIN) begin
            sine_sat = SINE_MIN[tsa_pkg::SINE_W-1:0];
        end else begin
            sine_sat = r_sum[tsa_pkg::SINE_W-1:0];
        end
    end

    tsa_reduce #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (red_start),
        .i_mag   (mag),
        .o_done  (red_done),
        .o_rem   (red_rem)
    );

    tsa_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mul_req),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .o_done   (mul_done),
        .o_result (mul_result)
    );

    tsa_div #(
        .DIVISOR_W (K_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_k),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        red_start     = 1'b0;
        mul_req.start = 1'b0;
        mul_req.mode  = tsa_pkg::MUL_SQUARE;
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            tsa_pkg::S_IDLE: begin
                if (s_accept) begin
                    red_start = 1'b1;
                    n_state   = tsa_pkg::S_REDUCE;
                end
            end
            tsa_pkg::S_REDUCE: begin
                if (red_done) begin
                    mul_req.start = 1'b1;
                    mul_req.mode  = tsa_pkg::MUL_SQUARE;
                    n_state       = tsa_pkg::S_SQUARE;
                end
            end
            tsa_pkg::S_SQUARE: begin
                if (mul_done) begin
                    n_state = tsa_pkg::S_ACCUM;
                end
            end
            tsa_pkg::S_ACCUM: begin
                // The term just added may be the last one
                if (term_small || count_full) begin
                    n_state = tsa_pkg::S_DONE;
                end else begin
                    mul_req.start = 1'b1;
                    mul_req.mode  = tsa_pkg::MUL_TERM;
                    n_state       = tsa_pkg::S_MUL;
                end
            end
            tsa_pkg::S_MUL: begin
                if (mul_done) begin
                    n_state = tsa_pkg::S_DIV_GO;
                end
            end
            tsa_pkg::S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = tsa_pkg::S_DIV;
            end
            tsa_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = tsa_pkg::S_ACCUM;
                end
            end
            tsa_pkg::S_DONE: begin
                // Hold until the output register is free or being drained
                if (!r_out_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = tsa_pkg::S_IDLE;
                end
            end
        endcase
    end

    // Epsilon register and output flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps       <= tsa_pkg::EPS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_eps <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_neg   <= i_s_axis_tdata[tsa_pkg::ANGLE_W-1];
            r_sum   <= '0;
            r_count <= '0;
            r_k     <= K_W'(K_FIRST);
            r_kinc  <= K_W'(K_STEP_1ST);
        end
        if (r_state == tsa_pkg::S_REDUCE && red_done) begin
            r_term <= term_first;
        end
        if (r_state == tsa_pkg::S_SQUARE && mul_done) begin
            r_x2 <= mul_result[tsa_pkg::X2_W-1:0];
        end
        if (r_state == tsa_pkg::S_ACCUM) begin
            r_sum   <= sum_next;
            r_count <= count_next;
            r_hit   <= !term_small;
        end
        if (r_state == tsa_pkg::S_MUL && mul_done) begin
            r_prod <= mul_result;
        end
        if (r_state == tsa_pkg::S_DIV && div_done) begin
            r_term <= div_quot[tsa_pkg::TERM_W-1:0];
            r_k    <= r_k + r_kinc;
            r_kinc <= r_kinc + K_W'(K_STEP_INC);
        end
        if (out_load) begin
            r_out_data <= {r_hit, r_count, sine_sat};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== sv/tsa_sva.sv =====
`timescale 1ns / 1ps
`include "taylor_sine_approximation_macros.svh"
module tsa_sva #(
    parameter int MAX_TERMS = tsa_pkg::MAX_TERMS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [tsa_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int CNT_LSB = tsa_pkg::SINE_W;
    localparam int CNT_MSB = tsa_pkg::SINE_W + tsa_pkg::CNT_W - 1;
    localparam int HIT_BIT = tsa_pkg::SINE_W + tsa_pkg::CNT_W;

    `TSA_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")
    `TSA_ASSERT_CLK(a_busy_after_take, i_clk, i_rst_n, (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready, "angle taken while busy")
    `TSA_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)), "stalled result changed")
    `TSA_ASSERT_CLK(a_terms_range, i_clk, i_rst_n, o_m_axis_tvalid |-> ((o_m_axis_tdata[CNT_MSB:CNT_LSB] != '0) && (o_m_axis_tdata[CNT_MSB:CNT_LSB] <= tsa_pkg::CNT_W'(MAX_TERMS))), "term count out of range")
    `TSA_ASSERT_CLK(a_hit_at_cap, i_clk, i_rst_n, (o_m_axis_tvalid && o_m_axis_tdata[HIT_BIT]) |-> (o_m_axis_tdata[CNT_MSB:CNT_LSB] == tsa_pkg::CNT_W'(MAX_TERMS)), "cap flag below term cap")

endmodule

bind taylor_sine_approximation tsa_sva #(.MAX_TERMS(MAX_TERMS)) u_tsa_sva (.*);

// ===== test/tsa_sine_checker.sv =====
`timescale 1ns / 1ps
module tsa_sine_checker #(
    parameter int MAX_TERMS       = tsa_pkg::MAX_TERMS_DEF,
    parameter int ANGLE_FRAC_BITS = tsa_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [tsa_pkg::EPS_W-1:0]       i_cfg_wr_data,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [tsa_pkg::ANGLE_W-1:0]     i_s_tdata,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [tsa_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int REPORT_LIMIT = 10;

    // Same bit order as the result tdata: hit_limit on top, sine_value at the bottom.
    typedef struct packed {
        logic                       hit_limit;
        logic [tsa_pkg::CNT_W-1:0]  terms_used;
        logic [tsa_pkg::SINE_W-1:0] sine_value;
    } t_sine_word;

    typedef struct {
        logic [tsa_pkg::ANGLE_W-1:0] angle;
        t_sine_word                  want;
    } t_sine_expect;

    t_sine_expect               sine_expect_q[$];
    logic [tsa_pkg::EPS_W-1:0]  epsilon = tsa_pkg::EPS_RESET;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Series sine of one angle: reduce modulo 2*pi, then add terms until one
    // drops to the threshold or the term cap is reached.
    function automatic t_sine_word predict_sine(input logic [tsa_pkg::ANGLE_W-1:0] angle,
                                                input logic [tsa_pkg::EPS_W-1:0] eps);
        logic               neg;
        logic               capped;
        logic               done;
        logic [63:0]        mag;
        logic [63:0]        red;
        logic [63:0]        x40;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        k;
        logic [127:0]       prod;
        logic signed [63:0] acc;
        int unsigned        count;
        int unsigned        n;
        t_sine_word         res;
        neg  = angle[tsa_pkg::ANGLE_W-1];
        mag  = neg ? (64'h1_0000_0000 - {32'd0, angle}) : {32'd0, angle};
        red  = (mag << (tsa_pkg::RED_FRAC - ANGLE_FRAC_BITS)) % 64'(tsa_pkg::TWO_PI_RED);
        x40  = (red + (64'd1 << 7)) >> 8;
        prod = {64'd0, x40} * {64'd0, x40};
        x2   = 64'((prod + (128'd1 << 49)) >> 50);
        term = (red + (64'd1 << 17)) >> 18;
        acc    = '0;
        count  = 0;
        n      = 0;
        capped = 1'b0;
        done   = 1'b0;
        while (!done) begin
            // Signs alternate, the first term taking the sign of the angle.
            if (neg ^ ((n % 2) == 1))
                acc = acc - $signed(term);
            else
                acc = acc + $signed(term);
            count++;
            if (term <= 64'(eps)) begin
                done = 1'b1;
            end else if (count >= MAX_TERMS) begin
                capped = 1'b1;
                done   = 1'b1;
            end else begin
                k    = 64'((2 * n + 2) * (2 * n + 3));
                prod = {64'd0, term} * {64'd0, x2};
                term = 64'((prod + (128'd1 << 29)) >> 30);
                term = (term + k / 2) / k;
                n++;
            end
        end
        if (acc > 64'sd2147483647)
            res.sine_value = 32'h7FFF_FFFF;
        else if (acc < -64'sd2147483648)
            res.sine_value = 32'h8000_0000;
        else
            res.sine_value = acc[31:0];
        res.terms_used = tsa_pkg::CNT_W'(count);
        res.hit_limit  = capped;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_sine_expect entry;
        t_sine_word   got;
        if (!i_rst_n) begin
            epsilon = tsa_pkg::EPS_RESET;
        end else begin
            if (i_cfg_wr_en)
                epsilon = i_cfg_wr_data;
            // Queue the expectation first so a same-cycle result still pops the oldest.
            if (i_s_tvalid && i_s_tready) begin
                entry.angle = i_s_tdata;
                entry.want  = predict_sine(i_s_tdata, epsilon);
                sine_expect_q.push_back(entry);
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_sine_word'(i_m_tdata);
                if (sine_expect_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT)
                        $display("unexpected result: sine %h terms %0d hit %0d",
                                 got.sine_value, got.terms_used, got.hit_limit);
                end else begin
                    entry = sine_expect_q.pop_front();
                    if (got.sine_value !== entry.want.sine_value ||
                        got.terms_used !== entry.want.terms_used ||
                        got.hit_limit  !== entry.want.hit_limit) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT)
                            $display({"angle %h: expected sine %h terms %0d hit %0d, ",
                                      "got sine %h terms %0d hit %0d"},
                                     entry.angle, entry.want.sine_value,
                                     entry.want.terms_used, entry.want.hit_limit,
                                     got.sine_value, got.terms_used, got.hit_limit);
                    end
                end
            end
        end
        o_pending = sine_expect_q.size();
    end

endmodule

// ===== test/tb_taylor_sine_approximation.sv =====
`timescale 1ns / 1ps
module tb_taylor_sine_approximation;

    localparam int MAX_TERMS       = tsa_pkg::MAX_TERMS_DEF;
    localparam int ANGLE_FRAC_BITS = tsa_pkg::ANGLE_FRAC_BITS_DEF;

    localparam int RESET_CYCLES  = 7;
    // Long enough for a full-length item to pass again at the end.
    localparam int SETTLE_CYCLES = 700;
    // Slowest run: ~850 items at the full term count plus stalls and the long hold.
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int PHASE_COUNT   = 6;
    localparam int PHASE_ITEMS   = 138;
    // Long output hold-off: start after this many angles, last this many cycles.
    localparam int HOLD_AT_ANGLE = 60;
    localparam int HOLD_CYCLES   = 4000;

    localparam logic [tsa_pkg::EPS_W-1:0] EPS_ZERO = '0;
    localparam logic [tsa_pkg::EPS_W-1:0] EPS_TOP  = 31'h4000_0000;  // 1.0 in Q.30

    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic [tsa_pkg::EPS_W-1:0]       cfg_wr_data = '0;
    logic                            s_tvalid    = 1'b0;
    logic [tsa_pkg::ANGLE_W-1:0]     s_tdata     = '0;
    logic                            m_tready    = 1'b0;
    logic                            s_tready;
    logic                            m_tvalid;
    logic [tsa_pkg::OUT_TDATA_W-1:0] m_tdata;

    int          fail_count;
    int          pending;
    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    int          angles_sent   = 0;
    int          hold_left     = 0;
    bit          hold_done     = 1'b0;
    int unsigned cycle_count   = 0;

    // Angles in Q8.24: the field extremes, zero and +-1 lsb, the quarter points of
    // a turn, one lsb around 2*pi, a few radians either side, and bit patterns.
    logic [tsa_pkg::ANGLE_W-1:0] directed_angles [0:19] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h0000_0002, 32'd26353589,  -32'sd26353589,
        32'd52707179,  -32'sd52707179, 32'd79060768, 32'd105414356,
        32'd105414357, -32'sd105414357, 32'd105414358, 32'h0100_0000,
        32'hFF00_0000, 32'h0000_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
    };

    always #1 clk = ~clk;

    taylor_sine_approximation #(
        .MAX_TERMS       (MAX_TERMS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    tsa_sine_checker #(
        .MAX_TERMS       (MAX_TERMS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) sine_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Hard stop in case the block hangs or loses a result.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random backpressure, plus one long hold-off once enough angles
    // have gone in, so the output register fills and the input side stalls.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && angles_sent >= HOLD_AT_ANGLE) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Half full-range angles, some within a few turns, some tiny ones within
    // 1/256 radian of zero.
    function automatic logic [tsa_pkg::ANGLE_W-1:0] pick_angle();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return $urandom;
        else if (sel < 8)
            return 32'($urandom_range(32'h1000_0000)) - 32'h0800_0000;
        else
            return 32'($urandom_range(32'h0002_0000)) - 32'h0001_0000;
    endfunction

    // Offer one angle, idling first at random. Call at a falling edge; returns at
    // the falling edge after the transfer with tvalid still high, so the next
    // call either keeps it up or drops it, never both in one step.
    task automatic send_angle(input logic [tsa_pkg::ANGLE_W-1:0] angle);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= angle;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        angles_sent++;
        @(negedge clk);
    endtask

    // Drop tvalid and hold until every queued result has been checked.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    // Write the threshold only with the block idle.
    task automatic set_epsilon(input logic [tsa_pkg::EPS_W-1:0] eps);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= eps;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int unsigned              phase;
        logic [tsa_pkg::EPS_W-1:0] eps;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed angles at the reset threshold, sender light, receiver heavy.
        src_idle_pct  = 26;
        sink_idle_pct = 79;
        foreach (directed_angles[i])
            send_angle(directed_angles[i]);

        // Random phases: two per idling pattern, threshold changed between each.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0:       eps = EPS_ZERO;
                1:       eps = EPS_TOP;
                2:       eps = tsa_pkg::EPS_W'($urandom_range(1023));
                3:       eps = tsa_pkg::EPS_W'($urandom_range(32'h4000_0000));
                4:       eps = tsa_pkg::EPS_RESET;
                default: eps = tsa_pkg::EPS_W'($urandom_range(64, 2));
            endcase
            set_epsilon(eps);
            if (phase < 2) begin
                src_idle_pct  = 26;
                sink_idle_pct = 79;
            end else if (phase < 4) begin
                src_idle_pct  = 79;
                sink_idle_pct = 26;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            repeat (PHASE_ITEMS)
                send_angle(pick_angle());
        end

        // Wait out the last results, then watch for strays.
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tsa_pkg.sv
sv/tsa_reduce.sv
sv/tsa_mul.sv
sv/tsa_div.sv
sv/taylor_sine_approximation.sv
sv/tsa_sva.sv
test/tsa_sine_checker.sv
test/tb_taylor_sine_approximation.sv
